// File: hw/rtl/sparse_coo_matrix_vector_multiply_macros.svh
// Assertion macros for the sparse COO matrix-vector block.
// Both macros sample on the rising edge of clk.
`ifndef SPARSE_COO_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define SPARSE_COO_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Check a property outside reset.
`define SCMV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SCMV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/scmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scmv_pkg;

	// Field widths fixed by the request and response formats
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int PROD_W = 2 * VAL_W;
	// Q16.16 fraction bits dropped after accumulation
	localparam int FRAC_W = 16;

	// Default sizes of the stores
	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int VECTOR_LEN_DEF = 1024;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_CLEAR     = 2'd0,
		CMD_APPEND    = 2'd1,
		CMD_VEC_WRITE = 2'd2,
		CMD_COMPUTE   = 2'd3
	} cmd_e;

	typedef struct packed {
		cmd_e                    cmd;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic signed [VAL_W-1:0] out_value;
		logic                    saturated;
		logic                    entries_dropped;
	} rsp_t;

	// One coordinate entry as held in the entry store
	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic rd_en;
	} ent_ctl_t;

	typedef struct packed {
		logic clear;
		logic valid;
		logic use_entry;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_e;

endpackage

`default_nettype wire

// File: hw/rtl/sparse_coo_matrix_vector_multiply.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                          Moves
// request   req_valid, req_ready, req        clear, append, vector write, row compute
// response  rsp_valid, rsp_ready, rsp        one product element per row compute
//
// After reset the vector store is swept to zero; req_ready is low.
// Clear, append and vector write are taken back to back.
// A row compute walks the entry store one entry per cycle through a read,
// vector read, multiply and accumulate pipeline.
// A waiting response holds in its output register while new requests are taken;
// a finished compute waits for that register to free up.

module sparse_coo_matrix_vector_multiply import scmv_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int VECTOR_LEN = VECTOR_LEN_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EA_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int VA_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

	state_e                  state_q;
	state_e                  state_d;
	logic [CNT_W-1:0]        idx_q;
	logic [IDX_W-1:0]        row_q;
	logic                    valid_s1;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    accept;
	logic                    last_issue;
	logic                    load_rsp;
	logic                    col_in_range;
	logic                    wr_in_range;
	logic                    hit_s1;
	ent_ctl_t                ent_ctl;
	mac_ctl_t                mac_ctl;
	entry_t                  wr_entry;
	entry_t                  rd_entry;
	logic [CNT_W-1:0]        count;
	logic                    dropped;
	logic                    vec_wr_en;
	logic signed [VAL_W-1:0] vec_rd_data;
	logic                    clearing;
	logic                    mac_busy;
	logic signed [VAL_W-1:0] mac_res;
	logic                    mac_sat;

	assign accept     = req_valid && req_ready;
	assign last_issue = (CNT_W'(idx_q + 1'b1) == count);

	// Entry lookup at stage 1: match row, check vector bounds
	assign col_in_range = (32'(rd_entry.col) < 32'(VECTOR_LEN));
	assign hit_s1       = valid_s1 && (rd_entry.row == row_q) && col_in_range;
	assign wr_in_range  = (32'(req.col_index) < 32'(VECTOR_LEN));

	assign wr_entry.row   = req.row_index;
	assign wr_entry.col   = req.col_index;
	assign wr_entry.value = req.value;

	// Next state and strobes
	always_comb begin
		state_d           = state_q;
		req_ready         = 1'b0;
		load_rsp          = 1'b0;
		ent_ctl.clear     = 1'b0;
		ent_ctl.append    = 1'b0;
		ent_ctl.rd_en     = 1'b0;
		vec_wr_en         = 1'b0;
		mac_ctl.clear     = 1'b0;
		mac_ctl.valid     = valid_s1;
		mac_ctl.use_entry = hit_s1;
		case (state_q)
			ST_INIT: begin
				if (!clearing) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req.cmd)
						CMD_CLEAR:     ent_ctl.clear  = 1'b1;
						CMD_APPEND:    ent_ctl.append = 1'b1;
						CMD_VEC_WRITE: vec_wr_en      = wr_in_range;
						CMD_COMPUTE: begin
							mac_ctl.clear = 1'b1;
							state_d = (count == '0) ? ST_DRAIN : ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				ent_ctl.rd_en = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1 && !mac_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan index and issue valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ent_ctl.rd_en;
			if (accept) begin
				idx_q <= '0;
			end else if (ent_ctl.rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Latch the row under compute
	always_ff @(posedge clk) begin
		if (accept && (req.cmd == CMD_COMPUTE)) begin
			row_q <= req.row_index;
		end
	end

	// Response register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.out_row         <= row_q;
			rsp_q.out_value       <= mac_res;
			rsp_q.saturated       <= mac_sat;
			rsp_q.entries_dropped <= dropped;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	scmv_entry_mem #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_entry_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ent_ctl),
		.wr_entry (wr_entry),
		.rd_addr  (idx_q[EA_W-1:0]),
		.dropped  (dropped),
		.count    (count),
		.rd_entry (rd_entry)
	);

	scmv_vec_mem #(
		.VECTOR_LEN(VECTOR_LEN)
	) u_vec_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (vec_wr_en),
		.wr_addr  (VA_W'(req.col_index)),
		.wr_data  (req.value),
		.rd_en    (hit_s1),
		.rd_addr  (VA_W'(rd_entry.col)),
		.rd_data  (vec_rd_data),
		.clearing (clearing)
	);

	scmv_mac #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.ent_value (rd_entry.value),
		.vec_value (vec_rd_data),
		.busy      (mac_busy),
		.res       (mac_res),
		.sat       (mac_sat)
	);

endmodule

`default_nettype wire

// File: hw/rtl/scmv_entry_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module scmv_entry_mem import scmv_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
	localparam int EA_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ent_ctl_t         ctl,
	input  wire entry_t           wr_entry,
	input  wire logic [EA_W-1:0]  rd_addr,
	output logic                  dropped,
	output logic [CNT_W-1:0]      count,
	output entry_t                rd_entry
);

	entry_t           ent_mem_q [MAX_ENTRIES];
	entry_t           rd_entry_q;
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic             full;
	logic             mem_we;

	assign full   = (count_q == CNT_W'(MAX_ENTRIES));
	assign mem_we = ctl.append && !full;

	// Track fill level and lost appends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (ctl.clear) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (ctl.append) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Append at the fill level, read through a register
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ent_mem_q[count_q[EA_W-1:0]] <= wr_entry;
		end
		if (ctl.rd_en) begin
			rd_entry_q <= ent_mem_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;
	assign count    = count_q;
	assign dropped  = dropped_q;

endmodule

`default_nettype wire

// File: hw/rtl/scmv_vec_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module scmv_vec_mem import scmv_pkg::*; #(
	parameter int VECTOR_LEN = VECTOR_LEN_DEF,
	localparam int VA_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    wr_en,
	input  wire logic [VA_W-1:0]         wr_addr,
	input  wire logic signed [VAL_W-1:0] wr_data,
	input  wire logic                    rd_en,
	input  wire logic [VA_W-1:0]         rd_addr,
	output logic signed [VAL_W-1:0]      rd_data,
	output logic                         clearing
);

	logic signed [VAL_W-1:0] vec_mem_q [VECTOR_LEN];
	logic signed [VAL_W-1:0] rd_data_q;
	logic [VA_W-1:0]         clr_q;
	logic                    clearing_q;

	// Sweep every element to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == VA_W'(VECTOR_LEN - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// Single write port shared by the sweep and element writes
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			vec_mem_q[clr_q] <= '0;
		end else if (wr_en) begin
			vec_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= vec_mem_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

// File: hw/rtl/scmv_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module scmv_mac import scmv_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
	localparam int ACC_W = PROD_W + CNT_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mac_ctl_t                ctl,
	input  wire logic signed [VAL_W-1:0] ent_value,
	input  wire logic signed [VAL_W-1:0] vec_value,
	output logic                         busy,
	output logic signed [VAL_W-1:0]      res,
	output logic                         sat
);

	logic                     valid_s2;
	logic                     valid_s3;
	logic                     use_s2;
	logic signed [VAL_W-1:0]  val_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-48:0]        upper;

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= ctl.valid;
			valid_s3 <= valid_s2;
		end
	end

	// Hold entry value until the vector element arrives, then multiply
	always_ff @(posedge clk) begin
		use_s2 <= ctl.use_entry;
		val_s2 <= ent_value;
		if (use_s2) begin
			prod_s3 <= val_s2 * vec_value;
		end else begin
			prod_s3 <= '0;
		end
	end

	// Accumulate exact products
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	// Drop fraction bits and clip to Q16.16
	assign upper = acc_q[ACC_W-1:FRAC_W+VAL_W-1];
	assign sat   = !((&upper) || !(|upper));

	always_comb begin
		if (sat) begin
			res = acc_q[ACC_W-1] ? VAL_MIN : VAL_MAX;
		end else begin
			res = acc_q[FRAC_W+VAL_W-1:FRAC_W];
		end
	end

	assign busy = valid_s2 || valid_s3;

endmodule

`default_nettype wire

// File: hw/rtl/scmv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_coo_matrix_vector_multiply_macros.svh"

module scmv_checker import scmv_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// Nothing is offered or taken while in reset
	`SCMV_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!rsp_valid && !req_ready), "active in reset")

	// A stalled response holds its payload
	`SCMV_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)), "response changed while stalled")

	// A row compute starts a scan, or a drain with an empty list, that blocks the next request
	`SCMV_ASSERT(a_compute_blocks, (req_valid && req_ready && (req.cmd == CMD_COMPUTE)) |=> !req_ready, "request taken during scan")

	// A new response only appears at the end of a compute
	`SCMV_ASSERT(a_rsp_from_compute, $rose(rsp_valid) |-> !$past(req_ready), "response without compute")

endmodule

bind sparse_coo_matrix_vector_multiply scmv_checker u_checker (.*);

`default_nettype wire
